// ===== hdl/sam_pkg.sv =====
// Shared types and constants for the stream arrival monitor.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sam_pkg;

    // Number of monitored sample streams.
    localparam int NUM_STREAMS = 3;

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int STREAM_W = 2;
    localparam int TIME_W   = 32;
    localparam int FIRST_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // First timed-out code meaning that no stream has timed out.
    localparam logic [FIRST_W-1:0] FIRST_NONE = 2'd3;

    // Command codes; the unused code behaves as a status query.
    typedef enum logic [CMD_W-1:0] {
        CMD_START  = 2'd0,
        CMD_ARRIVE = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_TIMEOUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TIMEOUT = 2'd1;

    // Configuration reset values.
    localparam logic [TIME_W-1:0] STREAM_TIMEOUT_RST  = 32'd1000000;
    localparam logic [TIME_W-1:0] INITIAL_TIMEOUT_RST = 32'd2000000;

    // Rate scale: millihertz from counts per microsecond.
    localparam int RATE_SCALE_W = 30;
    localparam logic [RATE_SCALE_W-1:0] RATE_SCALE = 30'd1000000000;
    localparam int PROD_W = 64;

    // Divider: two quotient bits per step over the full product width.
    localparam int DIV_STEPS = PROD_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // One classified command waiting for its rate division.
    typedef struct packed {
        logic               any_timed_out;
        logic [FIRST_W-1:0] first_timed_out;
        logic               stream_valid;
        logic [TIME_W-1:0]  sequence_res;
        logic [TIME_W-1:0]  peak_gap_us;
        logic [TIME_W-1:0]  age_us;
        logic [TIME_W-1:0]  gap_count;
        logic [TIME_W-1:0]  gap_sum;
        logic               rate_zero;
    } t_rec;

    // One finished result.
    typedef struct packed {
        logic               any_timed_out;
        logic [FIRST_W-1:0] first_timed_out;
        logic               stream_valid;
        logic [TIME_W-1:0]  sequence_res;
        logic [TIME_W-1:0]  rate_milli_hz;
        logic [TIME_W-1:0]  peak_gap_us;
        logic [TIME_W-1:0]  age_us;
    } t_res;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage

// ===== hdl/stream_arrival_monitor.sv =====
// Top level of the stream arrival monitor.
// Instantiates sam_front, sam_queue and sam_back; depends on sam_pkg.
//
// Every command (start, arrival, query) yields one result. The front end
// updates the per-stream statistics in the cycle a transaction is accepted
// and classifies it from the registered pending slot; records then wait in
// a two-entry queue. The back end loads each record, multiplies, then runs
// 32 divider steps of two quotient bits each and hands the result off,
// skipping the divider when the rate is zero, so the sustained rate is
// set by the back-end divider. Up to five commands can be in flight
// (pending slot, two queue entries, divider, output register), so full
// rises only after a burst. Configuration writes take effect at once.
module stream_arrival_monitor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sam_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sam_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [sam_pkg::CMD_W-1:0]        i_cmd,
    input  logic [sam_pkg::STREAM_W-1:0]     i_stream,
    input  logic [sam_pkg::TIME_W-1:0]       i_time_us,
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_any_timed_out,
    output logic [sam_pkg::FIRST_W-1:0]      o_first_timed_out,
    output logic                             o_stream_valid,
    output logic [sam_pkg::TIME_W-1:0]       o_sequence_res,
    output logic [sam_pkg::TIME_W-1:0]       o_rate_milli_hz,
    output logic [sam_pkg::TIME_W-1:0]       o_peak_gap_us,
    output logic [sam_pkg::TIME_W-1:0]       o_age_us
);

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    sam_pkg::t_rec q_wr_data;
    sam_pkg::t_rec q_rd_data;
    sam_pkg::t_res res;

    // Command acceptance and classification.
    sam_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_cmd      (i_cmd),
        .i_stream   (i_stream),
        .i_time_us  (i_time_us),
        .o_full     (full),
        .o_q_push   (q_push),
        .o_q_data   (q_wr_data),
        .i_q_full   (q_full)
    );

    // Decoupling queue.
    sam_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    // Rate computation and result delivery.
    sam_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rd_data),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_res     (res)
    );

    // Result fields.
    assign o_any_timed_out   = res.any_timed_out;
    assign o_first_timed_out = res.first_timed_out;
    assign o_stream_valid    = res.stream_valid;
    assign o_sequence_res    = res.sequence_res;
    assign o_rate_milli_hz   = res.rate_milli_hz;
    assign o_peak_gap_us     = res.peak_gap_us;
    assign o_age_us          = res.age_us;

endmodule

// ===== hdl/sam_front.sv =====
// Front end of the stream arrival monitor: accepts commands, keeps per-stream
// statistics and configuration, and classifies each command into a record.
// Depends on sam_pkg.
module sam_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sam_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sam_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_push,
    input  logic [sam_pkg::CMD_W-1:0]        i_cmd,
    input  logic [sam_pkg::STREAM_W-1:0]     i_stream,
    input  logic [sam_pkg::TIME_W-1:0]       i_time_us,
    output logic                             o_full,
    output logic                             o_q_push,
    output sam_pkg::t_rec                    o_q_data,
    input  logic                             i_q_full
);

    // Configuration registers.
    logic [sam_pkg::TIME_W-1:0] r_stream_to;
    logic [sam_pkg::TIME_W-1:0] r_initial_to;

    // Per-stream statistics and the start time.
    logic                       r_seen    [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] r_last    [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] r_sum     [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] r_cnt     [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] r_max     [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] r_arr     [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] r_start;

    // Pending command whose statistics have been updated but not yet reported.
    logic                         r_pend_vld;
    logic [sam_pkg::STREAM_W-1:0] r_pend_stream;
    logic [sam_pkg::TIME_W-1:0]   r_pend_time;

    logic accept;
    logic advance;

    // The pending slot empties into the queue whenever the queue has room.
    assign advance  = r_pend_vld && !i_q_full;
    assign o_full   = r_pend_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = advance;

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_to  <= sam_pkg::STREAM_TIMEOUT_RST;
            r_initial_to <= sam_pkg::INITIAL_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sam_pkg::CFG_STREAM_TIMEOUT:  r_stream_to  <= i_cfg_data;
                sam_pkg::CFG_INITIAL_TIMEOUT: r_initial_to <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Statistics update for an accepted start or arrival transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            for (int k = 0; k < sam_pkg::NUM_STREAMS; k++) begin
                r_seen[k] <= 1'b0;
                r_last[k] <= '0;
                r_sum[k]  <= '0;
                r_cnt[k]  <= '0;
                r_max[k]  <= '0;
                r_arr[k]  <= '0;
            end
        end else if (accept) begin
            if (i_cmd == sam_pkg::CMD_START) begin
                r_start <= i_time_us;
                for (int k = 0; k < sam_pkg::NUM_STREAMS; k++) begin
                    r_seen[k] <= 1'b0;
                    r_last[k] <= '0;
                    r_sum[k]  <= '0;
                    r_cnt[k]  <= '0;
                    r_max[k]  <= '0;
                    r_arr[k]  <= '0;
                end
            end else if (i_cmd == sam_pkg::CMD_ARRIVE) begin
                for (int k = 0; k < sam_pkg::NUM_STREAMS; k++) begin
                    if (int'(i_stream) == k) begin
                        if (r_seen[k]) begin
                            r_sum[k] <= r_sum[k] + (i_time_us - r_last[k]);
                            r_cnt[k] <= r_cnt[k] + 32'd1;
                            if ((i_time_us - r_last[k]) > r_max[k]) begin
                                r_max[k] <= i_time_us - r_last[k];
                            end
                        end
                        r_last[k] <= i_time_us;
                        r_arr[k]  <= r_arr[k] + 32'd1;
                        r_seen[k] <= 1'b1;
                    end
                end
            end
        end
    end

    // Pending slot control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (accept) begin
            r_pend_vld <= 1'b1;
        end else if (advance) begin
            r_pend_vld <= 1'b0;
        end
    end

    // Pending payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_stream <= i_stream;
            r_pend_time   <= i_time_us;
        end
    end

    // Timeout status and named-stream fields, taken after the update.
    always_comb begin
        logic [sam_pkg::TIME_W-1:0] ref_time;
        logic                       timed_out;
        logic                       sel_seen;
        logic [sam_pkg::TIME_W-1:0] sel_last;
        logic [sam_pkg::TIME_W-1:0] sel_sum;
        logic [sam_pkg::TIME_W-1:0] sel_cnt;
        logic [sam_pkg::TIME_W-1:0] sel_max;
        logic [sam_pkg::TIME_W-1:0] sel_arr;

        o_q_data  = '0;
        sel_seen  = 1'b0;
        sel_last  = '0;
        sel_sum   = '0;
        sel_cnt   = '0;
        sel_max   = '0;
        sel_arr   = '0;
        o_q_data.first_timed_out = sam_pkg::FIRST_NONE;

        // Scan from the top so that the lowest timed-out stream wins.
        for (int k = sam_pkg::NUM_STREAMS - 1; k >= 0; k--) begin
            ref_time  = r_seen[k] ? r_last[k] : r_start;
            timed_out = ((r_pend_time - ref_time) >= r_stream_to) &&
                        ((r_pend_time - r_start) >= r_initial_to);
            if (timed_out) begin
                o_q_data.any_timed_out   = 1'b1;
                o_q_data.first_timed_out = (k < 3) ? 2'(k) : sam_pkg::FIRST_NONE;
            end
        end

        // Pick the named stream; an index out of range reads as never seen.
        for (int k = 0; k < sam_pkg::NUM_STREAMS; k++) begin
            if (int'(r_pend_stream) == k) begin
                sel_seen = r_seen[k];
                sel_last = r_last[k];
                sel_sum  = r_sum[k];
                sel_cnt  = r_cnt[k];
                sel_max  = r_max[k];
                sel_arr  = r_arr[k];
            end
        end

        o_q_data.stream_valid = sel_seen;
        o_q_data.sequence_res = sel_arr;
        o_q_data.peak_gap_us  = sel_max;
        o_q_data.age_us       = sel_seen ? (r_pend_time - sel_last) : '1;
        o_q_data.gap_count    = sel_cnt;
        o_q_data.gap_sum      = sel_sum;
        o_q_data.rate_zero    = (sel_cnt == '0) || (sel_sum == '0);
    end

endmodule

// ===== hdl/sam_queue.sv =====
// Short record queue between the front and back of the arrival monitor.
// Flip-flop storage; depends on sam_pkg for the record type and depth.
module sam_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sam_pkg::t_rec i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sam_pkg::t_rec o_data
);

    sam_pkg::t_rec               r_mem [sam_pkg::QUEUE_DEPTH];
    logic [sam_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [sam_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [sam_pkg::QCNT_W-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == sam_pkg::QCNT_W'(sam_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == sam_pkg::QPTR_W'(sam_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == sam_pkg::QPTR_W'(sam_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Record storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/sam_back.sv =====
// Back end of the arrival monitor: computes the rate with a multiply and a
// two-bit-per-step restoring divider, then holds the result for the consumer.
// Depends on sam_pkg.
module sam_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  sam_pkg::t_rec i_q_data,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output sam_pkg::t_res o_res
);

    sam_pkg::t_back_state r_state;
    sam_pkg::t_back_state n_state;

    sam_pkg::t_rec                  r_rec;
    logic [sam_pkg::PROD_W-1:0]     r_num;
    logic [sam_pkg::TIME_W-1:0]     r_rem;
    logic [sam_pkg::TIME_W-1:0]     r_quo;
    logic [sam_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           r_out_vld;
    sam_pkg::t_res                  r_out;

    logic                           out_free;
    logic [sam_pkg::TIME_W:0]       trial1;
    logic [sam_pkg::TIME_W:0]       trial2;
    logic                           bit1;
    logic                           bit2;
    logic [sam_pkg::TIME_W-1:0]     rem1;
    logic [sam_pkg::TIME_W-1:0]     rem2;

    assign out_free = !r_out_vld || i_pop;
    assign o_empty  = !r_out_vld;
    assign o_res    = r_out;

    // Two restoring division steps per cycle.
    always_comb begin
        trial1 = {r_rem, r_num[sam_pkg::PROD_W-1]};
        bit1   = trial1 >= {1'b0, r_rec.gap_sum};
        rem1   = bit1 ? sam_pkg::TIME_W'(trial1 - {1'b0, r_rec.gap_sum})
                      : trial1[sam_pkg::TIME_W-1:0];
        trial2 = {rem1, r_num[sam_pkg::PROD_W-2]};
        bit2   = trial2 >= {1'b0, r_rec.gap_sum};
        rem2   = bit2 ? sam_pkg::TIME_W'(trial2 - {1'b0, r_rec.gap_sum})
                      : trial2[sam_pkg::TIME_W-1:0];
    end

    // Next state and queue pop.
    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        case (r_state)
            sam_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = sam_pkg::BK_MUL;
                end
            end
            sam_pkg::BK_MUL: begin
                n_state = r_rec.rate_zero ? sam_pkg::BK_DONE : sam_pkg::BK_DIV;
            end
            sam_pkg::BK_DIV: begin
                if (r_cnt == sam_pkg::DIV_CNT_W'(sam_pkg::DIV_STEPS - 1)) begin
                    n_state = sam_pkg::BK_DONE;
                end
            end
            sam_pkg::BK_DONE: begin
                if (out_free) begin
                    n_state = sam_pkg::BK_IDLE;
                end
            end
            default: n_state = sam_pkg::BK_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sam_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: load, multiply, divide.
    always_ff @(posedge i_clk) begin
        case (r_state)
            sam_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    r_rec <= i_q_data;
                end
            end
            sam_pkg::BK_MUL: begin
                // Both operands are widened so the product keeps all 64 bits.
                r_num <= {32'd0, r_rec.gap_count} *
                         sam_pkg::PROD_W'(sam_pkg::RATE_SCALE);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= '0;
            end
            sam_pkg::BK_DIV: begin
                r_num <= {r_num[sam_pkg::PROD_W-3:0], 2'b00};
                r_rem <= rem2;
                r_quo <= {r_quo[sam_pkg::TIME_W-3:0], bit1, bit2};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == sam_pkg::BK_DONE && out_free) begin
            r_out_vld <= 1'b1;
        end else if (i_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (r_state == sam_pkg::BK_DONE && out_free) begin
            r_out.any_timed_out   <= r_rec.any_timed_out;
            r_out.first_timed_out <= r_rec.first_timed_out;
            r_out.stream_valid    <= r_rec.stream_valid;
            r_out.sequence_res    <= r_rec.sequence_res;
            r_out.rate_milli_hz   <= r_quo;
            r_out.peak_gap_us     <= r_rec.peak_gap_us;
            r_out.age_us          <= r_rec.age_us;
        end
    end

endmodule

// ===== hdl/sam_checker.sv =====
// Port-level checker for the stream arrival monitor, bound to the top level.
// Depends on sam_pkg and stream_arrival_monitor.
module sam_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         empty,
    input  logic                         pop,
    input  logic                         o_any_timed_out,
    input  logic [sam_pkg::FIRST_W-1:0]  o_first_timed_out,
    input  logic                         o_stream_valid,
    input  logic [sam_pkg::TIME_W-1:0]   o_sequence_res,
    input  logic [sam_pkg::TIME_W-1:0]   o_rate_milli_hz,
    input  logic [sam_pkg::TIME_W-1:0]   o_peak_gap_us,
    input  logic [sam_pkg::TIME_W-1:0]   o_age_us
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // A waiting result that is not taken stays on the ports.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_age_us) && $stable(o_rate_milli_hz))
        else $error("waiting result changed or vanished without a pop");

    // No timeout flag means the first timed-out code is none.
    a_first_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_any_timed_out |-> o_first_timed_out == sam_pkg::FIRST_NONE)
        else $error("first timed-out stream reported without a timeout");

    // A never-seen stream has no statistics and an all-ones age.
    a_unseen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_stream_valid |-> o_age_us == '1 && o_sequence_res == '0 &&
        o_rate_milli_hz == '0 && o_peak_gap_us == '0)
        else $error("statistics reported for a stream that never arrived");

endmodule

bind stream_arrival_monitor sam_checker u_sam_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .empty             (empty),
    .pop               (pop),
    .o_any_timed_out   (o_any_timed_out),
    .o_first_timed_out (o_first_timed_out),
    .o_stream_valid    (o_stream_valid),
    .o_sequence_res    (o_sequence_res),
    .o_rate_milli_hz   (o_rate_milli_hz),
    .o_peak_gap_us     (o_peak_gap_us),
    .o_age_us          (o_age_us)
);

// ===== bench/testbench.sv =====
// Self-checking bench for stream_arrival_monitor: directed and random commands,
// predicted in place and compared result by result. Depends on sam_pkg and the RTL.
module testbench;

    // Codes outside the package enums that the stimulus still drives.
    localparam logic [sam_pkg::CMD_W-1:0]     CMD_SPARE  = 2'd3;
    localparam logic [sam_pkg::STREAM_W-1:0]  STREAM_BAD = 2'd3;
    localparam logic [sam_pkg::CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam int                            CYCLE_LIMIT = 1000000;
    localparam int                            PHASE_ITEMS = 300;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [sam_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [sam_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           push = 1'b0;
    logic                           full;
    logic [sam_pkg::CMD_W-1:0]      cmd_in = '0;
    logic [sam_pkg::STREAM_W-1:0]   stream_in = '0;
    logic [sam_pkg::TIME_W-1:0]     time_in = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic                           any_out;
    logic [sam_pkg::FIRST_W-1:0]    first_out;
    logic                           valid_out;
    logic [sam_pkg::TIME_W-1:0]     seq_out;
    logic [sam_pkg::TIME_W-1:0]     rate_out;
    logic [sam_pkg::TIME_W-1:0]     gap_out;
    logic [sam_pkg::TIME_W-1:0]     age_out;

    // Predicted monitor state and register copies.
    bit                         arrived [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] last_seen_us [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] gap_total [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] gap_num [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] gap_peak [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] seq_num [sam_pkg::NUM_STREAMS];
    logic [sam_pkg::TIME_W-1:0] t_start;
    logic [sam_pkg::TIME_W-1:0] lim_silence;
    logic [sam_pkg::TIME_W-1:0] lim_grace;

    // Statuses predicted for accepted commands, oldest first.
    sam_pkg::t_res pending_status [$];

    // Free-running time used by the random traffic.
    logic [sam_pkg::TIME_W-1:0] now_us = '0;

    int  n_sent = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    int  gap_left = 0;
    bit  send_quiet = 1'b0;
    bit  recv_quiet = 1'b0;

    stream_arrival_monitor dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .push              (push),
        .full              (full),
        .i_cmd             (cmd_in),
        .i_stream          (stream_in),
        .i_time_us         (time_in),
        .empty             (empty),
        .pop               (pop),
        .o_any_timed_out   (any_out),
        .o_first_timed_out (first_out),
        .o_stream_valid    (valid_out),
        .o_sequence_res    (seq_out),
        .o_rate_milli_hz   (rate_out),
        .o_peak_gap_us     (gap_out),
        .o_age_us          (age_out)
    );

    always #5 clk = ~clk;

    // Run-length guard.
    always @(posedge clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_status.size());
            $display("stream_arrival_monitor regression: fail");
            $finish;
        end
    end

    // Applies one command to the predicted state and returns its status.
    function automatic sam_pkg::t_res predict_status(
            input logic [sam_pkg::CMD_W-1:0] cmd,
            input logic [sam_pkg::STREAM_W-1:0] sid,
            input logic [sam_pkg::TIME_W-1:0] now);
        sam_pkg::t_res              r;
        int                         k;
        bit                         hit;
        logic [sam_pkg::TIME_W-1:0] gap;
        logic [sam_pkg::TIME_W-1:0] quiet_since;
        logic [sam_pkg::TIME_W-1:0] silence;
        logic [sam_pkg::TIME_W-1:0] since_start;
        logic [sam_pkg::PROD_W-1:0] prod;
        r = '0;
        r.first_timed_out = sam_pkg::FIRST_NONE;
        hit = 1'b0;
        if (cmd == sam_pkg::CMD_START) begin
            for (k = 0; k < sam_pkg::NUM_STREAMS; k++) begin
                arrived[k] = 1'b0;
                last_seen_us[k] = '0;
                gap_total[k] = '0;
                gap_num[k] = '0;
                gap_peak[k] = '0;
                seq_num[k] = '0;
            end
            t_start = now;
        end else if (cmd == sam_pkg::CMD_ARRIVE && sid < sam_pkg::NUM_STREAMS) begin
            if (arrived[sid]) begin
                gap = now - last_seen_us[sid];
                gap_total[sid] = gap_total[sid] + gap;
                gap_num[sid] = gap_num[sid] + 32'd1;
                if (gap > gap_peak[sid]) begin
                    gap_peak[sid] = gap;
                end
            end
            last_seen_us[sid] = now;
            seq_num[sid] = seq_num[sid] + 32'd1;
            arrived[sid] = 1'b1;
        end
        // Timeout status of all streams after the update; lowest index wins.
        since_start = now - t_start;
        for (k = 0; k < sam_pkg::NUM_STREAMS; k++) begin
            quiet_since = arrived[k] ? last_seen_us[k] : t_start;
            silence = now - quiet_since;
            if (!hit && silence >= lim_silence && since_start >= lim_grace) begin
                hit = 1'b1;
                r.any_timed_out = 1'b1;
                r.first_timed_out = (k < 3) ? sam_pkg::FIRST_W'(k) : sam_pkg::FIRST_NONE;
            end
        end
        r.age_us = '1;
        if (sid < sam_pkg::NUM_STREAMS) begin
            r.stream_valid = arrived[sid];
            r.sequence_res = seq_num[sid];
            r.peak_gap_us = gap_peak[sid];
            if (gap_num[sid] != 0 && gap_total[sid] != 0) begin
                prod = 64'd1000000000 * {32'd0, gap_num[sid]};
                prod = prod / {32'd0, gap_total[sid]};
                r.rate_milli_hz = prod[sam_pkg::TIME_W-1:0];
            end
            if (arrived[sid]) begin
                r.age_us = now - last_seen_us[sid];
            end
        end
        return r;
    endfunction

    // Offers one command after a random gap and predicts it on acceptance.
    task automatic send_command(input logic [sam_pkg::CMD_W-1:0] cmd,
                                input logic [sam_pkg::STREAM_W-1:0] sid,
                                input logic [sam_pkg::TIME_W-1:0] now);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_in = cmd;
        stream_in = sid;
        time_in = now;
        push = 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        pending_status.push_back(predict_status(cmd, sid, now));
        n_sent = n_sent + 1;
    endtask

    // Stops offering and waits until every predicted status has come back.
    task automatic wait_drained();
        @(negedge clk);
        push = 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_register(input logic [sam_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [sam_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        push = 1'b0;
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            sam_pkg::CFG_STREAM_TIMEOUT:  lim_silence = value;
            sam_pkg::CFG_INITIAL_TIMEOUT: lim_grace = value;
            default: ;
        endcase
    endtask

    // Receiver: random pop gaps plus an optional long hold-off.
    always @(negedge clk) begin
        if (!rst_n) begin
            pop = 1'b0;
        end else if (hold_left > 0) begin
            pop = 1'b0;
            hold_left = hold_left - 1;
        end else if (gap_left > 0) begin
            pop = 1'b0;
            gap_left = gap_left - 1;
        end else begin
            pop = 1'b1;
        end
    end

    task automatic check_field(input string what,
                               input logic [sam_pkg::TIME_W-1:0] want,
                               input logic [sam_pkg::TIME_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
            n_errors = n_errors + 1;
        end
    endtask

    // Compare each popped transaction with the oldest prediction.
    always @(posedge clk) begin
        sam_pkg::t_res want;
        if (rst_n && pop && !empty) begin
            if (pending_status.size() == 0) begin
                $display("%0t: result with nothing expected: seq %h age %h", $time,
                         seq_out, age_out);
                n_errors = n_errors + 1;
            end else begin
                want = pending_status.pop_front();
                check_field("any_timed_out", sam_pkg::TIME_W'(want.any_timed_out),
                            sam_pkg::TIME_W'(any_out));
                check_field("first_timed_out", sam_pkg::TIME_W'(want.first_timed_out),
                            sam_pkg::TIME_W'(first_out));
                check_field("stream_valid", sam_pkg::TIME_W'(want.stream_valid),
                            sam_pkg::TIME_W'(valid_out));
                check_field("sequence_res", want.sequence_res, seq_out);
                check_field("rate_milli_hz", want.rate_milli_hz, rate_out);
                check_field("peak_gap_us", want.peak_gap_us, gap_out);
                check_field("age_us", want.age_us, age_out);
            end
            n_checked = n_checked + 1;
            gap_left = recv_quiet ? 0 : $urandom_range(0, 14);
        end
    end

    // Queries before any start, with reset timeouts, on every stream code.
    task automatic test_reset_state();
        send_command(sam_pkg::CMD_QUERY, 2'd0, 32'd0);
        send_command(sam_pkg::CMD_QUERY, STREAM_BAD, 32'hFFFF_FFFF);
        send_command(CMD_SPARE, 2'd1, 32'd2500000);
        send_command(sam_pkg::CMD_QUERY, 2'd2, 32'd1500000);
        wait_drained();
    endtask

    // Arrivals across the time wrap, an ignored out-of-range arrival and a
    // stream that never arrives.
    task automatic test_wrapping_gaps();
        send_command(sam_pkg::CMD_START, 2'd0, 32'hFFFF_FF00);
        send_command(sam_pkg::CMD_ARRIVE, 2'd0, 32'hFFFF_FF00);
        send_command(sam_pkg::CMD_ARRIVE, 2'd0, 32'h0000_0100);
        send_command(sam_pkg::CMD_ARRIVE, 2'd0, 32'h0000_0110);
        send_command(sam_pkg::CMD_ARRIVE, STREAM_BAD, 32'h0000_0120);
        send_command(sam_pkg::CMD_QUERY, 2'd2, 32'h0000_0130);
        wait_drained();
    endtask

    // Zero gaps keep the sum at zero; a one-microsecond gap then makes the
    // rate overflow 32 bits.
    task automatic test_rate_overflow();
        int i;
        for (i = 0; i < 5; i++) begin
            send_command(sam_pkg::CMD_ARRIVE, 2'd1, 32'h0000_0200);
        end
        send_command(sam_pkg::CMD_ARRIVE, 2'd1, 32'h0000_0201);
        wait_drained();
    endtask

    // Zero limits, all-ones limits, and a case where only the last stream
    // has timed out.
    task automatic test_timeout_limits();
        write_register(sam_pkg::CFG_STREAM_TIMEOUT, 32'd0);
        write_register(sam_pkg::CFG_INITIAL_TIMEOUT, 32'd0);
        send_command(sam_pkg::CMD_QUERY, 2'd0, 32'h1234_5678);
        wait_drained();
        write_register(sam_pkg::CFG_STREAM_TIMEOUT, 32'hFFFF_FFFF);
        write_register(sam_pkg::CFG_INITIAL_TIMEOUT, 32'hFFFF_FFFF);
        send_command(sam_pkg::CMD_START, 2'd2, 32'd10);
        send_command(sam_pkg::CMD_QUERY, 2'd1, 32'd9);
        send_command(sam_pkg::CMD_ARRIVE, 2'd0, 32'd9);
        wait_drained();
        write_register(sam_pkg::CFG_STREAM_TIMEOUT, 32'd100);
        write_register(sam_pkg::CFG_INITIAL_TIMEOUT, 32'd0);
        send_command(sam_pkg::CMD_START, 2'd0, 32'd1000);
        send_command(sam_pkg::CMD_ARRIVE, 2'd0, 32'd1100);
        send_command(sam_pkg::CMD_ARRIVE, 2'd1, 32'd1100);
        send_command(sam_pkg::CMD_QUERY, 2'd2, 32'd1150);
        wait_drained();
    endtask

    // A write to an index with no register must leave both limits alone.
    task automatic test_unused_register();
        write_register(CFG_SPARE, 32'h0000_0001);
        send_command(sam_pkg::CMD_QUERY, 2'd0, 32'd1250);
        wait_drained();
    endtask

    // One random command on the running time line.
    task automatic send_random_item();
        int                           r;
        logic [sam_pkg::CMD_W-1:0]    cmd;
        logic [sam_pkg::STREAM_W-1:0] sid;
        r = $urandom_range(0, 99);
        if (r < 10) begin
        end else if (r < 70) begin
            now_us = now_us + $urandom_range(1, 2000);
        end else if (r < 90) begin
            now_us = now_us + $urandom_range(1, 200000);
        end else if (r < 97) begin
            now_us = now_us + $urandom_range(1, 3000000);
        end else begin
            now_us = $urandom;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            cmd = sam_pkg::CMD_START;
        end else if (r < 70) begin
            cmd = sam_pkg::CMD_ARRIVE;
        end else if (r < 92) begin
            cmd = sam_pkg::CMD_QUERY;
        end else begin
            cmd = CMD_SPARE;
        end
        sid = ($urandom_range(0, 99) < 6) ? STREAM_BAD
                                          : sam_pkg::STREAM_W'($urandom_range(0, 2));
        send_command(cmd, sid, now_us);
    endtask

    // Receiver stalls long enough for the block to fill and push back.
    task automatic test_backpressure();
        int i;
        hold_left = 400;
        send_quiet = 1'b1;
        for (i = 0; i < 30; i++) begin
            send_random_item();
        end
        send_quiet = 1'b0;
        wait_drained();
    endtask

    // Random traffic under a series of timeout settings, extremes included.
    task automatic test_random_traffic();
        logic [sam_pkg::TIME_W-1:0] silence_set [5];
        logic [sam_pkg::TIME_W-1:0] grace_set [5];
        int                         p;
        int                         i;
        int                         mode;
        silence_set = '{sam_pkg::STREAM_TIMEOUT_RST, 32'd500, 32'd0, 32'hFFFF_FFFF, 32'd0};
        grace_set = '{sam_pkg::INITIAL_TIMEOUT_RST, 32'd3000, 32'd0, 32'hFFFF_FFFF, 32'd0};
        silence_set[4] = $urandom_range(0, 4000000);
        grace_set[4] = $urandom_range(0, 8000000);
        for (p = 0; p < 5; p++) begin
            write_register(sam_pkg::CFG_STREAM_TIMEOUT, silence_set[p]);
            write_register(sam_pkg::CFG_INITIAL_TIMEOUT, grace_set[p]);
            if ($urandom_range(0, 1) == 1) begin
                send_command(sam_pkg::CMD_START,
                             sam_pkg::STREAM_W'($urandom_range(0, 3)), now_us);
            end
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // Stretches of 50 with and without idling on either side.
                if (i % 50 == 0) begin
                    mode = $urandom_range(0, 3);
                    send_quiet = (mode == 0 || mode == 1);
                    recv_quiet = (mode == 0 || mode == 2);
                end
                send_random_item();
            end
            send_quiet = 1'b0;
            recv_quiet = 1'b0;
            wait_drained();
        end
    endtask

    initial begin
        lim_silence = sam_pkg::STREAM_TIMEOUT_RST;
        lim_grace = sam_pkg::INITIAL_TIMEOUT_RST;
        t_start = '0;
        for (int k = 0; k < sam_pkg::NUM_STREAMS; k++) begin
            arrived[k] = 1'b0;
            last_seen_us[k] = '0;
            gap_total[k] = '0;
            gap_num[k] = '0;
            gap_peak[k] = '0;
            seq_num[k] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_wrapping_gaps();
        test_rate_overflow();
        test_timeout_limits();
        test_unused_register();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (50) @(posedge clk);
        $display("Sent %0d commands and checked %0d results: wrapping gaps, rate overflow,",
                 n_sent, n_checked);
        $display("timeout limit extremes, a long receiver stall and random traffic.");
        if (n_errors == 0) begin
            $display("stream_arrival_monitor regression: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("stream_arrival_monitor regression: fail");
        end
        $finish;
    end

endmodule
